### rtl/positional_list_engine_assert.svh
// Assertion macros used by the positional list engine back end.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("positional list engine: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("positional list engine: next-cycle check failed");

`endif

### rtl/plist_pkg.sv
// Package: word types, operation codes, status codes and defaults of the list engine.
package plist_pkg;

   // Field widths of the request and response words
   localparam int OP_FIELD_W   = 4;
   localparam int RD_FIELD_W   = 2;
   localparam int POS_FIELD_W  = 7;
   localparam int ELEM_FIELD_W = 32;
   localparam int STAT_FIELD_W = 2;
   localparam int CNT_FIELD_W  = 7;

   // Parameter defaults
   localparam int CAPACITY_DEFAULT      = 64;
   localparam int ELEMENT_WIDTH_DEFAULT = 32;

   // Operation codes
   localparam logic [OP_FIELD_W-1:0] OP_INSERT_HEAD = 4'd0;
   localparam logic [OP_FIELD_W-1:0] OP_INSERT_POS  = 4'd1;
   localparam logic [OP_FIELD_W-1:0] OP_INSERT_TAIL = 4'd2;
   localparam logic [OP_FIELD_W-1:0] OP_REMOVE_HEAD = 4'd3;
   localparam logic [OP_FIELD_W-1:0] OP_REMOVE_POS  = 4'd4;
   localparam logic [OP_FIELD_W-1:0] OP_REMOVE_TAIL = 4'd5;
   localparam logic [OP_FIELD_W-1:0] OP_SET_HEAD    = 4'd6;
   localparam logic [OP_FIELD_W-1:0] OP_SET_POS     = 4'd7;
   localparam logic [OP_FIELD_W-1:0] OP_SET_TAIL    = 4'd8;
   localparam logic [OP_FIELD_W-1:0] OP_CLEAR       = 4'd9;

   // Read request codes
   localparam logic [RD_FIELD_W-1:0] RD_NONE  = 2'd0;
   localparam logic [RD_FIELD_W-1:0] RD_HEAD  = 2'd1;
   localparam logic [RD_FIELD_W-1:0] RD_OTHER = 2'd2;

   // Response status codes
   localparam logic [STAT_FIELD_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_FIELD_W-1:0] STAT_FULL   = 2'd1;
   localparam logic [STAT_FIELD_W-1:0] STAT_EMPTY  = 2'd2;
   localparam logic [STAT_FIELD_W-1:0] STAT_BADPOS = 2'd3;

   typedef struct packed {
      logic [OP_FIELD_W-1:0]   operation;
      logic [RD_FIELD_W-1:0]   read_request;
      logic [POS_FIELD_W-1:0]  position;
      logic [ELEM_FIELD_W-1:0] element;
   } plist_req_type;

   typedef struct packed {
      logic [STAT_FIELD_W-1:0] status;
      logic [ELEM_FIELD_W-1:0] element_out;
      logic [CNT_FIELD_W-1:0]  count;
   } plist_rsp_type;

   // Decoded command kinds and list places
   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_READ,
      KIND_INSERT,
      KIND_REMOVE,
      KIND_SET,
      KIND_CLEAR
   } plist_kind_type;

   typedef enum logic [1:0] {
      PLACE_HEAD,
      PLACE_POS,
      PLACE_TAIL
   } plist_place_type;

   // Command word handed from the front end to the execution back end
   typedef struct packed {
      plist_kind_type          kind;
      plist_place_type         place;
      logic [POS_FIELD_W-1:0]  position;
      logic [ELEM_FIELD_W-1:0] element;
   } plist_cmd_type;

endpackage

### rtl/plist_front.sv
// Front end: accepts request words, decodes them into commands and queues them.
module plist_front
   import plist_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  plist_req_type req_word,
   output logic          cmd_valid,
   output plist_cmd_type cmd,
   input  logic          cmd_pop
);

   localparam int QDEPTH = 2;
   localparam int QPW    = $clog2(QDEPTH);
   localparam int QFW    = $clog2(QDEPTH + 1);

   plist_cmd_type  cmd_in;
   plist_cmd_type  slot_ff [QDEPTH];
   logic [QPW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QFW-1:0] fill_ff, fill_in;
   logic           push;
   logic           positional;

   // Decode: a read request overrides the operation code
   always_comb begin
      positional = (req_word.operation == OP_INSERT_POS) ||
                   (req_word.operation == OP_REMOVE_POS) ||
                   (req_word.operation == OP_SET_POS);
      cmd_in.position = req_word.position;
      cmd_in.element  = req_word.element;
      cmd_in.kind     = KIND_NOP;
      cmd_in.place    = PLACE_HEAD;
      if (req_word.read_request == RD_HEAD) begin
         cmd_in.kind  = KIND_READ;
         cmd_in.place = PLACE_HEAD;
      end else if (req_word.read_request == RD_OTHER) begin
         cmd_in.kind  = KIND_READ;
         cmd_in.place = positional ? PLACE_POS : PLACE_TAIL;
      end else begin
         case (req_word.operation)
            OP_INSERT_HEAD: begin
               cmd_in.kind  = KIND_INSERT;
               cmd_in.place = PLACE_HEAD;
            end
            OP_INSERT_POS: begin
               cmd_in.kind  = KIND_INSERT;
               cmd_in.place = PLACE_POS;
            end
            OP_INSERT_TAIL: begin
               cmd_in.kind  = KIND_INSERT;
               cmd_in.place = PLACE_TAIL;
            end
            OP_REMOVE_HEAD: begin
               cmd_in.kind  = KIND_REMOVE;
               cmd_in.place = PLACE_HEAD;
            end
            OP_REMOVE_POS: begin
               cmd_in.kind  = KIND_REMOVE;
               cmd_in.place = PLACE_POS;
            end
            OP_REMOVE_TAIL: begin
               cmd_in.kind  = KIND_REMOVE;
               cmd_in.place = PLACE_TAIL;
            end
            OP_SET_HEAD: begin
               cmd_in.kind  = KIND_SET;
               cmd_in.place = PLACE_HEAD;
            end
            OP_SET_POS: begin
               cmd_in.kind  = KIND_SET;
               cmd_in.place = PLACE_POS;
            end
            OP_SET_TAIL: begin
               cmd_in.kind  = KIND_SET;
               cmd_in.place = PLACE_TAIL;
            end
            OP_CLEAR: begin
               cmd_in.kind  = KIND_CLEAR;
               cmd_in.place = PLACE_HEAD;
            end
            default: begin
               cmd_in.kind  = KIND_NOP;
               cmd_in.place = PLACE_HEAD;
            end
         endcase
      end
   end

   // Command queue control
   assign req_stall = (fill_ff == QFW'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (fill_ff != '0);
   assign cmd       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPW'(1) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + QPW'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !cmd_pop) begin
         fill_in = fill_ff + QFW'(1);
      end else if (!push && cmd_pop) begin
         fill_in = fill_ff - QFW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue slots hold payload only
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

### rtl/plist_back.sv
// Back end: list store, shift sequencer and response register.
`include "positional_list_engine_assert.svh"

module plist_back
   import plist_pkg::*;
#(
   parameter int CAPACITY      = CAPACITY_DEFAULT,
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEFAULT
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          cmd_valid,
   input  plist_cmd_type cmd,
   output logic          cmd_pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output plist_rsp_type rsp_word
);

   localparam int SW = (ELEMENT_WIDTH < ELEM_FIELD_W) ? ELEMENT_WIDTH : ELEM_FIELD_W;
   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_FIELD_W) ? CW : POS_FIELD_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ_WAIT,
      S_REM_FETCH,
      S_SHIFT_UP,
      S_SHIFT_DOWN,
      S_PUT,
      S_RESULT
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [IW-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0]           tgt_ff, tgt_in;
   logic [SW-1:0]           value_ff, value_in;
   logic [STAT_FIELD_W-1:0] res_status_ff, res_status_in;
   logic [SW-1:0]           res_elem_ff, res_elem_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   plist_rsp_type           rsp_word_ff, rsp_word_in;

   logic [SW-1:0]           store_mem [CAPACITY];
   logic [SW-1:0]           rd_data_ff;
   logic                    mem_we;
   logic [IW-1:0]           mem_waddr;
   logic [SW-1:0]           mem_wdata;
   logic [IW-1:0]           mem_raddr;

   logic                    empty;
   logic                    full;
   logic                    pos_ok;
   logic [PW-1:0]           pos_ext;
   logic [IW-1:0]           pos_idx;
   logic [IW-1:0]           tail_idx;
   logic [IW-1:0]           end_idx;
   logic [IW-1:0]           sel_idx;
   logic [IW-1:0]           ins_idx;

   // Place checks against the current count
   always_comb begin
      empty    = (count_ff == '0);
      full     = (count_ff == CW'(CAPACITY));
      pos_ext  = PW'(cmd.position);
      pos_ok   = (cmd.position != '0) && (pos_ext <= PW'(count_ff));
      pos_idx  = IW'(pos_ext - PW'(1));
      tail_idx = IW'(count_ff - CW'(1));
      end_idx  = IW'(count_ff);
      case (cmd.place)
         PLACE_HEAD: begin
            sel_idx = '0;
            ins_idx = '0;
         end
         PLACE_POS: begin
            sel_idx = pos_idx;
            ins_idx = pos_idx;
         end
         PLACE_TAIL: begin
            sel_idx = tail_idx;
            ins_idx = end_idx;
         end
         default: begin
            sel_idx = '0;
            ins_idx = '0;
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      wr_ptr_in     = wr_ptr_ff;
      tgt_in        = tgt_ff;
      value_in      = value_ff;
      res_status_in = res_status_ff;
      res_elem_in   = res_elem_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_word_in   = rsp_word_ff;
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = wr_ptr_ff;
      mem_wdata     = rd_data_ff;
      mem_raddr     = '0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop       = 1'b1;
               value_in      = SW'(cmd.element);
               res_status_in = STAT_OK;
               res_elem_in   = '0;
               state_in      = S_RESULT;
               case (cmd.kind)
                  KIND_READ: begin
                     if (empty) begin
                        res_status_in = STAT_EMPTY;
                     end else if (cmd.place == PLACE_POS && !pos_ok) begin
                        res_status_in = STAT_BADPOS;
                     end else begin
                        mem_raddr = sel_idx;
                        state_in  = S_READ_WAIT;
                     end
                  end
                  KIND_INSERT: begin
                     if (cmd.place == PLACE_POS && !pos_ok) begin
                        res_status_in = STAT_BADPOS;
                     end else if (full) begin
                        res_status_in = STAT_FULL;
                     end else begin
                        tgt_in = ins_idx;
                        if (ins_idx == end_idx) begin
                           state_in = S_PUT;
                        end else begin
                           mem_raddr = tail_idx;
                           wr_ptr_in = end_idx;
                           state_in  = S_SHIFT_UP;
                        end
                     end
                  end
                  KIND_REMOVE: begin
                     if (empty) begin
                        res_status_in = STAT_EMPTY;
                     end else if (cmd.place == PLACE_POS && !pos_ok) begin
                        res_status_in = STAT_BADPOS;
                     end else begin
                        mem_raddr = sel_idx;
                        tgt_in    = sel_idx;
                        state_in  = S_REM_FETCH;
                     end
                  end
                  KIND_SET: begin
                     if (empty) begin
                        res_status_in = STAT_EMPTY;
                     end else if (cmd.place == PLACE_POS && !pos_ok) begin
                        res_status_in = STAT_BADPOS;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = sel_idx;
                        mem_wdata = SW'(cmd.element);
                     end
                  end
                  KIND_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ_WAIT: begin
            res_elem_in = rd_data_ff;
            state_in    = S_RESULT;
         end
         S_REM_FETCH: begin
            // Capture the removed element, then close the gap if any
            res_elem_in = rd_data_ff;
            if (CW'(tgt_ff) + CW'(1) == count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = S_RESULT;
            end else begin
               mem_raddr = IW'(CW'(tgt_ff) + CW'(1));
               wr_ptr_in = tgt_ff;
               state_in  = S_SHIFT_DOWN;
            end
         end
         S_SHIFT_DOWN: begin
            // Entry at wr_ptr+1 moves down; next read two ahead
            mem_we = 1'b1;
            if (CW'(wr_ptr_ff) + CW'(2) == count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = S_RESULT;
            end else begin
               mem_raddr = IW'(CW'(wr_ptr_ff) + CW'(2));
               wr_ptr_in = IW'(CW'(wr_ptr_ff) + CW'(1));
            end
         end
         S_SHIFT_UP: begin
            // Entry at wr_ptr-1 moves up; next read two behind
            mem_we = 1'b1;
            if (wr_ptr_ff == IW'(CW'(tgt_ff) + CW'(1))) begin
               state_in = S_PUT;
            end else begin
               mem_raddr = IW'(CW'(wr_ptr_ff) - CW'(2));
               wr_ptr_in = IW'(CW'(wr_ptr_ff) - CW'(1));
            end
         end
         S_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = tgt_ff;
            mem_wdata = value_ff;
            count_in  = count_ff + CW'(1);
            state_in  = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.status      = res_status_ff;
               rsp_word_in.element_out = ELEM_FIELD_W'(res_elem_ff);
               rsp_word_in.count       = CNT_FIELD_W'(count_ff);
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wr_ptr_ff     <= wr_ptr_in;
      tgt_ff        <= tgt_in;
      value_ff      <= value_in;
      res_status_ff <= res_status_in;
      res_elem_ff   <= res_elem_in;
      rsp_word_ff   <= rsp_word_in;
   end

   // Element store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= store_mem[mem_raddr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `PLE_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `PLE_ASSERT_NEXT(a_put_grows, clock, reset, state_ff == S_PUT, count_ff == $past(count_ff) + CW'(1))
   `PLE_ASSERT_SAME(a_fail_zero, clock, reset, rsp_valid_ff && rsp_word_ff.status != STAT_OK, rsp_word_ff.element_out == '0)

endmodule

### rtl/positional_list_engine.sv
// Top level of the positional list engine: front end, command queue and back end.
//
//   channel   ports                          direction   word
//   request   req_valid req_stall req_word   in          plist_req_type
//   response  rsp_valid rsp_stall rsp_word   out         plist_rsp_type
//
// One word in gives one word out, in order. Set, clear, no-op and failing requests
// go from idle straight to the result state; reads, appends and tail removals pass
// a store access state first; other inserts and removals also shift the entries
// past the place, one entry per cycle, through the element store with its one
// write port and one registered read port. A stalled response holds the back end
// in its result state. Reset clears the count, the queue and the response valid;
// store contents are not cleared. The two-word queue keeps taking requests until
// it is full, while the back end is busy or the response is stalled.
module positional_list_engine
   import plist_pkg::*;
#(
   parameter int CAPACITY      = CAPACITY_DEFAULT,
   parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEFAULT
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  plist_req_type req_word,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output plist_rsp_type rsp_word
);

   logic          cmd_valid;
   logic          cmd_pop;
   plist_cmd_type cmd;

   plist_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   plist_back #(
      .CAPACITY      (CAPACITY),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
